// File: hw/rtl/i2c_register_master_assert.svh
// Assertion macros used by the checker of the I2C register master.
`ifndef I2C_REGISTER_MASTER_ASSERT_SVH
`define I2C_REGISTER_MASTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while in reset.
`define I2CRM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("i2c_register_master: check failed");

// Next-cycle implication, sampled on i_clk, off while in reset.
`define I2CRM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("i2c_register_master: check failed");

`endif

// File: hw/rtl/i2crm_pkg.sv
`timescale 1ns / 1ps

package i2crm_pkg;

    // Field widths
    localparam int ADDR_W   = 7;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int BUF_AW   = 4;
    localparam int BUF_DEPTH = 16;
    localparam int TICK_W   = 10;
    localparam int BIT_W    = 4;

    localparam logic [LEN_W-1:0]  MAX_LEN         = 5'd16;
    localparam logic [TICK_W-1:0] DEF_PHASE_TICKS = 10'd15;
    localparam logic [BIT_W-1:0]  BITS_PER_BYTE   = 4'd8;

    // Request opcodes
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LOAD  = 2'd1,
        OP_WRITE = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Completion status
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_START_FAIL = 2'd1,
        ST_ADDR_NACK  = 2'd2,
        ST_DATA_NACK  = 2'd3
    } t_status;

    // Kind of byte on the wire
    typedef enum logic [1:0] {
        KIND_ADDR_W = 2'd0,
        KIND_REG    = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_ADDR_R = 2'd3
    } t_kind;

    // Bus phases
    typedef enum logic [4:0] {
        PH_IDLE   = 5'd0,
        PH_ST_A   = 5'd1,
        PH_ST_B   = 5'd2,
        PH_ST_C   = 5'd3,
        PH_TX_LO  = 5'd4,
        PH_TX_SET = 5'd5,
        PH_TX_HI  = 5'd6,
        PH_AK_LO  = 5'd7,
        PH_AK_REL = 5'd8,
        PH_AK_HI  = 5'd9,
        PH_RX_LO  = 5'd10,
        PH_RX_HI  = 5'd11,
        PH_MA_LO  = 5'd12,
        PH_MA_SET = 5'd13,
        PH_MA_HI  = 5'd14,
        PH_MA_END = 5'd15,
        PH_SP_LO  = 5'd16,
        PH_SP_SDA = 5'd17,
        PH_SP_HI  = 5'd18,
        PH_SP_REL = 5'd19
    } t_phase;

    // Write buffer store request
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] idx;
        logic [BYTE_W-1:0] data;
    } t_wbuf_wr;

    // Result of one request
    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              rd_valid;
        logic [BUF_AW-1:0] rd_index;
        logic [BYTE_W-1:0] rd_byte;
        logic              busy;
        logic              done;
        t_status           status;
    } t_result;

endpackage

// File: hw/rtl/i2c_register_master.sv
// I2C register master, one bus phase per phase_ticks tick requests.
// The result of a request is registered and shows on the output in the cycle after it is accepted.
// Throughput: one request per cycle; a request is held off only while a result
// waits in the output register under a stall.
// Reset (synchronous, active low): idle, SCL and SDA released high, phase_ticks 15,
// output empty; the write buffer holds whatever it held before.
`timescale 1ns / 1ps

module i2c_register_master (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_op,
    input  logic                            i_sda_in,
    input  logic [i2crm_pkg::ADDR_W-1:0]    i_dev_addr,
    input  logic [i2crm_pkg::BYTE_W-1:0]    i_reg_addr,
    input  logic [i2crm_pkg::LEN_W-1:0]     i_xfer_len,
    input  logic [i2crm_pkg::BUF_AW-1:0]    i_wr_index,
    input  logic [i2crm_pkg::BYTE_W-1:0]    i_wr_byte,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_scl_out,
    output logic                            o_sda_out,
    output logic                            o_rd_valid,
    output logic [i2crm_pkg::BUF_AW-1:0]    o_rd_index,
    output logic [i2crm_pkg::BYTE_W-1:0]    o_rd_byte,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic [1:0]                      o_status,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [i2crm_pkg::TICK_W-1:0]    i_cfg_data
);

    logic [i2crm_pkg::TICK_W-1:0]   r_phase_ticks;
    logic                           r_out_valid, n_out_valid;
    i2crm_pkg::t_result             r_out;

    logic                           acc;
    logic [i2crm_pkg::TICK_W-1:0]   phase_len;
    i2crm_pkg::t_wbuf_wr            wbuf_wr;
    logic [i2crm_pkg::BUF_AW-1:0]   wbuf_idx;
    logic [i2crm_pkg::BYTE_W-1:0]   wbuf_data;
    i2crm_pkg::t_result             res;

    // Accept while the output register is free or draining
    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Zero phase length acts as one
    assign phase_len = (r_phase_ticks == '0) ?
                       {{(i2crm_pkg::TICK_W-1){1'b0}}, 1'b1} : r_phase_ticks;

    // Hold the phase length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= i2crm_pkg::DEF_PHASE_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_phase_ticks <= i_cfg_data;
        end
    end

    // Write buffer; the slot of the next byte to send is set up a full byte
    // ahead, so the registered read is ready when the byte is loaded
    i2crm_wbuf #(
        .WIDTH (i2crm_pkg::BYTE_W),
        .DEPTH (i2crm_pkg::BUF_DEPTH)
    ) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (wbuf_wr.we),
        .i_waddr (wbuf_wr.idx),
        .i_wdata (wbuf_wr.data),
        .i_raddr (wbuf_idx),
        .o_rdata (wbuf_data)
    );

    i2crm_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_op          (i_op),
        .i_sda_in      (i_sda_in),
        .i_dev_addr    (i_dev_addr),
        .i_reg_addr    (i_reg_addr),
        .i_xfer_len    (i_xfer_len),
        .i_wr_index    (i_wr_index),
        .i_wr_byte     (i_wr_byte),
        .i_phase_ticks (phase_len),
        .o_wr          (wbuf_wr),
        .o_rd_idx      (wbuf_idx),
        .i_rd_data     (wbuf_data),
        .o_res         (res)
    );

    // Advance the output valid
    always_comb begin
        if (acc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Capture the result of each accepted request
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl_out   = r_out.scl;
    assign o_sda_out   = r_out.sda;
    assign o_rd_valid  = r_out.rd_valid;
    assign o_rd_index  = r_out.rd_index;
    assign o_rd_byte   = r_out.rd_byte;
    assign o_busy_res  = r_out.busy;
    assign o_done_res  = r_out.done;
    assign o_status    = r_out.status;

endmodule

// File: hw/rtl/i2crm_wbuf.sv
`timescale 1ns / 1ps

module i2crm_wbuf #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(DEPTH)-1:0]    i_waddr,
    input  logic [WIDTH-1:0]            i_wdata,
    input  logic [$clog2(DEPTH)-1:0]    i_raddr,
    output logic [WIDTH-1:0]            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Store on write, fetch into the read register every cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/i2crm_ctrl.sv
`timescale 1ns / 1ps

module i2crm_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic [1:0]                      i_op,
    input  logic                            i_sda_in,
    input  logic [i2crm_pkg::ADDR_W-1:0]    i_dev_addr,
    input  logic [i2crm_pkg::BYTE_W-1:0]    i_reg_addr,
    input  logic [i2crm_pkg::LEN_W-1:0]     i_xfer_len,
    input  logic [i2crm_pkg::BUF_AW-1:0]    i_wr_index,
    input  logic [i2crm_pkg::BYTE_W-1:0]    i_wr_byte,
    input  logic [i2crm_pkg::TICK_W-1:0]    i_phase_ticks,
    output i2crm_pkg::t_wbuf_wr             o_wr,
    output logic [i2crm_pkg::BUF_AW-1:0]    o_rd_idx,
    input  logic [i2crm_pkg::BYTE_W-1:0]    i_rd_data,
    output i2crm_pkg::t_result              o_res
);

    i2crm_pkg::t_phase                  r_phase, n_phase;
    logic [i2crm_pkg::TICK_W-1:0]       r_tick, n_tick;
    logic [i2crm_pkg::BIT_W-1:0]        r_bit, n_bit;
    logic [i2crm_pkg::LEN_W-1:0]        r_byte, n_byte;
    logic [i2crm_pkg::BYTE_W-1:0]       r_shift, n_shift;
    logic [i2crm_pkg::ADDR_W-1:0]       r_addr, n_addr;
    logic [i2crm_pkg::BYTE_W-1:0]       r_reg, n_reg;
    logic [i2crm_pkg::LEN_W-1:0]        r_len, n_len;
    logic                               r_is_read, n_is_read;
    logic                               r_scl, n_scl;
    logic                               r_sda, n_sda;
    i2crm_pkg::t_kind                   r_kind, n_kind;
    i2crm_pkg::t_status                 r_fstat, n_fstat;

    i2crm_pkg::t_op                     op;
    logic [i2crm_pkg::TICK_W:0]         tick_p1;
    logic [i2crm_pkg::LEN_W-1:0]        byte_p1;
    logic                               do_enter;
    logic                               ev_done;
    i2crm_pkg::t_status                 ev_status;
    logic                               ev_rd_valid;
    logic [i2crm_pkg::BUF_AW-1:0]       ev_rd_index;
    logic [i2crm_pkg::BYTE_W-1:0]       ev_rd_byte;

    // Byte to shift out for a given kind
    function automatic logic [i2crm_pkg::BYTE_W-1:0] tx_byte(
        input i2crm_pkg::t_kind              k,
        input logic [i2crm_pkg::ADDR_W-1:0]  addr,
        input logic [i2crm_pkg::BYTE_W-1:0]  regb,
        input logic [i2crm_pkg::BYTE_W-1:0]  data
    );
        logic [i2crm_pkg::BYTE_W-1:0] b;
        case (k)
            i2crm_pkg::KIND_ADDR_W: b = {addr, 1'b0};
            i2crm_pkg::KIND_REG:    b = regb;
            i2crm_pkg::KIND_DATA:   b = data;
            default:                b = {addr, 1'b1};
        endcase
        return b;
    endfunction

    assign op      = i2crm_pkg::t_op'(i_op);
    assign tick_p1 = {1'b0, r_tick} + {{i2crm_pkg::TICK_W{1'b0}}, 1'b1};
    assign byte_p1 = r_byte + {{(i2crm_pkg::LEN_W-1){1'b0}}, 1'b1};

    // Buffer slot for the next data byte: the slot after the current byte while data is sent, else slot zero
    assign o_rd_idx = (r_kind == i2crm_pkg::KIND_DATA) ?
                      byte_p1[i2crm_pkg::BUF_AW-1:0] : '0;

    // Store a loaded byte while idle
    always_comb begin
        o_wr.we   = i_acc && (op == i2crm_pkg::OP_LOAD) && (r_phase == i2crm_pkg::PH_IDLE);
        o_wr.idx  = i_wr_index;
        o_wr.data = i_wr_byte;
    end

    // Next state and result
    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_byte      = r_byte;
        n_shift     = r_shift;
        n_addr      = r_addr;
        n_reg       = r_reg;
        n_len       = r_len;
        n_is_read   = r_is_read;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_kind      = r_kind;
        n_fstat     = r_fstat;
        do_enter    = 1'b0;
        ev_done     = 1'b0;
        ev_status   = i2crm_pkg::ST_OK;
        ev_rd_valid = 1'b0;
        ev_rd_index = '0;
        ev_rd_byte  = '0;

        if (i_acc && (op == i2crm_pkg::OP_TICK) && (r_phase != i2crm_pkg::PH_IDLE)) begin
            if (tick_p1 >= {1'b0, i_phase_ticks}) begin
                n_tick = '0;
                case (r_phase)
                    i2crm_pkg::PH_ST_A, i2crm_pkg::PH_ST_B: begin
                        // Start check: SDA must follow the driven level
                        if ((r_phase == i2crm_pkg::PH_ST_A) ? !i_sda_in : i_sda_in) begin
                            if (r_kind == i2crm_pkg::KIND_ADDR_R) begin
                                n_kind   = i2crm_pkg::KIND_ADDR_R;
                                n_shift  = tx_byte(i2crm_pkg::KIND_ADDR_R, r_addr, r_reg,
                                                   i_rd_data);
                                n_bit    = '0;
                                n_phase  = i2crm_pkg::PH_TX_LO;
                                do_enter = 1'b1;
                            end else begin
                                n_phase   = i2crm_pkg::PH_IDLE;
                                ev_done   = 1'b1;
                                ev_status = i2crm_pkg::ST_START_FAIL;
                            end
                        end else begin
                            n_phase  = (r_phase == i2crm_pkg::PH_ST_A) ?
                                       i2crm_pkg::PH_ST_B : i2crm_pkg::PH_ST_C;
                            do_enter = 1'b1;
                        end
                    end
                    i2crm_pkg::PH_ST_C: begin
                        n_shift  = tx_byte(r_kind, r_addr, r_reg, i_rd_data);
                        n_bit    = '0;
                        n_phase  = i2crm_pkg::PH_TX_LO;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_TX_LO: begin
                        n_phase  = i2crm_pkg::PH_TX_SET;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_TX_SET: begin
                        n_phase  = i2crm_pkg::PH_TX_HI;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_TX_HI: begin
                        n_shift  = {r_shift[i2crm_pkg::BYTE_W-2:0], 1'b0};
                        n_bit    = r_bit + {{(i2crm_pkg::BIT_W-1){1'b0}}, 1'b1};
                        n_phase  = (n_bit >= i2crm_pkg::BITS_PER_BYTE) ?
                                   i2crm_pkg::PH_AK_LO : i2crm_pkg::PH_TX_LO;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_AK_LO: begin
                        n_phase  = i2crm_pkg::PH_AK_REL;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_AK_REL: begin
                        n_phase  = i2crm_pkg::PH_AK_HI;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_AK_HI: begin
                        n_scl    = 1'b0;
                        do_enter = 1'b1;
                        case (r_kind)
                            i2crm_pkg::KIND_ADDR_W: begin
                                if (i_sda_in) begin
                                    n_fstat = i2crm_pkg::ST_ADDR_NACK;
                                    n_phase = i2crm_pkg::PH_SP_LO;
                                end else begin
                                    n_kind  = i2crm_pkg::KIND_REG;
                                    n_shift = r_reg;
                                    n_bit   = '0;
                                    n_phase = i2crm_pkg::PH_TX_LO;
                                end
                            end
                            i2crm_pkg::KIND_REG: begin
                                if (r_is_read) begin
                                    n_kind  = i2crm_pkg::KIND_ADDR_R;
                                    n_phase = i2crm_pkg::PH_ST_A;
                                end else begin
                                    n_byte = '0;
                                    if (r_len == '0) begin
                                        n_fstat = i2crm_pkg::ST_OK;
                                        n_phase = i2crm_pkg::PH_SP_LO;
                                    end else begin
                                        n_kind  = i2crm_pkg::KIND_DATA;
                                        n_shift = i_rd_data;
                                        n_bit   = '0;
                                        n_phase = i2crm_pkg::PH_TX_LO;
                                    end
                                end
                            end
                            i2crm_pkg::KIND_DATA: begin
                                if (i_sda_in) begin
                                    n_fstat = i2crm_pkg::ST_DATA_NACK;
                                    n_phase = i2crm_pkg::PH_SP_LO;
                                end else begin
                                    n_byte = byte_p1;
                                    if (byte_p1 >= r_len) begin
                                        n_fstat = i2crm_pkg::ST_OK;
                                        n_phase = i2crm_pkg::PH_SP_LO;
                                    end else begin
                                        n_shift = i_rd_data;
                                        n_bit   = '0;
                                        n_phase = i2crm_pkg::PH_TX_LO;
                                    end
                                end
                            end
                            default: begin
                                n_byte = '0;
                                if (r_len == '0) begin
                                    n_fstat = i2crm_pkg::ST_OK;
                                    n_phase = i2crm_pkg::PH_SP_LO;
                                end else begin
                                    n_sda   = 1'b1;
                                    n_shift = '0;
                                    n_bit   = '0;
                                    n_phase = i2crm_pkg::PH_RX_LO;
                                end
                            end
                        endcase
                    end
                    i2crm_pkg::PH_RX_LO: begin
                        n_phase  = i2crm_pkg::PH_RX_HI;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_RX_HI: begin
                        // Shift in one bit, MSB first
                        n_shift  = {r_shift[i2crm_pkg::BYTE_W-2:0], i_sda_in};
                        n_bit    = r_bit + {{(i2crm_pkg::BIT_W-1){1'b0}}, 1'b1};
                        do_enter = 1'b1;
                        if (n_bit >= i2crm_pkg::BITS_PER_BYTE) begin
                            ev_rd_valid = 1'b1;
                            ev_rd_index = r_byte[i2crm_pkg::BUF_AW-1:0];
                            ev_rd_byte  = n_shift;
                            n_phase     = i2crm_pkg::PH_MA_LO;
                        end else begin
                            n_phase = i2crm_pkg::PH_RX_LO;
                        end
                    end
                    i2crm_pkg::PH_MA_LO: begin
                        n_phase  = i2crm_pkg::PH_MA_SET;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_MA_SET: begin
                        n_phase  = i2crm_pkg::PH_MA_HI;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_MA_HI: begin
                        n_phase  = i2crm_pkg::PH_MA_END;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_MA_END: begin
                        n_byte   = byte_p1;
                        do_enter = 1'b1;
                        if (byte_p1 >= r_len) begin
                            n_fstat = i2crm_pkg::ST_OK;
                            n_phase = i2crm_pkg::PH_SP_LO;
                        end else begin
                            n_sda   = 1'b1;
                            n_shift = '0;
                            n_bit   = '0;
                            n_phase = i2crm_pkg::PH_RX_LO;
                        end
                    end
                    i2crm_pkg::PH_SP_LO: begin
                        n_phase  = i2crm_pkg::PH_SP_SDA;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_SP_SDA: begin
                        n_phase  = i2crm_pkg::PH_SP_HI;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_SP_HI: begin
                        n_phase  = i2crm_pkg::PH_SP_REL;
                        do_enter = 1'b1;
                    end
                    i2crm_pkg::PH_SP_REL: begin
                        n_phase   = i2crm_pkg::PH_IDLE;
                        ev_done   = 1'b1;
                        ev_status = r_fstat;
                    end
                    default: begin
                        n_phase = i2crm_pkg::PH_IDLE;
                    end
                endcase
            end else begin
                n_tick = tick_p1[i2crm_pkg::TICK_W-1:0];
            end
        end else if (i_acc && r_phase == i2crm_pkg::PH_IDLE &&
                     (op == i2crm_pkg::OP_WRITE || op == i2crm_pkg::OP_READ)) begin
            // Latch the command and open with START
            n_addr    = i_dev_addr;
            n_reg     = i_reg_addr;
            n_len     = (i_xfer_len > i2crm_pkg::MAX_LEN) ? i2crm_pkg::MAX_LEN : i_xfer_len;
            n_is_read = (op == i2crm_pkg::OP_READ);
            n_byte    = '0;
            n_bit     = '0;
            n_shift   = '0;
            n_fstat   = i2crm_pkg::ST_OK;
            n_kind    = i2crm_pkg::KIND_ADDR_W;
            n_phase   = i2crm_pkg::PH_ST_A;
            do_enter  = 1'b1;
        end

        // Drive the lines for the phase being entered
        if (do_enter) begin
            n_tick = '0;
            case (n_phase)
                i2crm_pkg::PH_ST_A: begin
                    n_sda = 1'b1;
                    n_scl = 1'b1;
                end
                i2crm_pkg::PH_ST_B, i2crm_pkg::PH_SP_SDA: begin
                    n_sda = 1'b0;
                end
                i2crm_pkg::PH_TX_LO, i2crm_pkg::PH_AK_LO, i2crm_pkg::PH_RX_LO,
                i2crm_pkg::PH_MA_LO, i2crm_pkg::PH_MA_END, i2crm_pkg::PH_SP_LO: begin
                    n_scl = 1'b0;
                end
                i2crm_pkg::PH_TX_SET: begin
                    n_sda = n_shift[i2crm_pkg::BYTE_W-1];
                end
                i2crm_pkg::PH_TX_HI, i2crm_pkg::PH_AK_HI, i2crm_pkg::PH_RX_HI,
                i2crm_pkg::PH_MA_HI, i2crm_pkg::PH_SP_HI: begin
                    n_scl = 1'b1;
                end
                i2crm_pkg::PH_AK_REL, i2crm_pkg::PH_SP_REL: begin
                    n_sda = 1'b1;
                end
                i2crm_pkg::PH_MA_SET: begin
                    // NACK the last byte, ACK the others
                    n_sda = (({1'b0, n_byte} + {{i2crm_pkg::LEN_W{1'b0}}, 1'b1}) >=
                             {1'b0, r_len});
                end
                default: begin
                end
            endcase
        end

        o_res.scl      = n_scl;
        o_res.sda      = n_sda;
        o_res.rd_valid = ev_rd_valid;
        o_res.rd_index = ev_rd_index;
        o_res.rd_byte  = ev_rd_byte;
        o_res.busy     = (n_phase != i2crm_pkg::PH_IDLE);
        o_res.done     = ev_done;
        o_res.status   = ev_status;
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= i2crm_pkg::PH_IDLE;
            r_tick    <= '0;
            r_bit     <= '0;
            r_byte    <= '0;
            r_shift   <= '0;
            r_addr    <= '0;
            r_reg     <= '0;
            r_len     <= '0;
            r_is_read <= 1'b0;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_kind    <= i2crm_pkg::KIND_ADDR_W;
            r_fstat   <= i2crm_pkg::ST_OK;
        end else begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit     <= n_bit;
            r_byte    <= n_byte;
            r_shift   <= n_shift;
            r_addr    <= n_addr;
            r_reg     <= n_reg;
            r_len     <= n_len;
            r_is_read <= n_is_read;
            r_scl     <= n_scl;
            r_sda     <= n_sda;
            r_kind    <= n_kind;
            r_fstat   <= n_fstat;
        end
    end

endmodule

// File: hw/rtl/i2crm_chk.sv
`timescale 1ns / 1ps
`include "i2c_register_master_assert.svh"

module i2crm_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_out_valid,
    input  logic                            i_out_stall,
    input  logic                            o_scl_out,
    input  logic                            o_sda_out,
    input  logic                            o_rd_valid,
    input  logic [i2crm_pkg::BUF_AW-1:0]    o_rd_index,
    input  logic [i2crm_pkg::BYTE_W-1:0]    o_rd_byte,
    input  logic                            o_busy_res,
    input  logic                            o_done_res,
    input  logic [1:0]                      o_status
);

    // A completed read byte leaves the master acking, so it stays busy
    `I2CRM_ASSERT_IMP(a_rd_keeps_busy, o_out_valid && o_rd_valid, o_busy_res)

    // A finished transaction leaves the master idle
    `I2CRM_ASSERT_IMP(a_done_idle, o_out_valid && o_done_res, !o_busy_res)

    // Status is reported only with completion
    `I2CRM_ASSERT_IMP(a_status_quiet, o_out_valid && !o_done_res,
                      o_status == i2crm_pkg::ST_OK)

    // A stalled result holds
    `I2CRM_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall,
                      o_out_valid && $stable(o_scl_out) && $stable(o_sda_out) &&
                      $stable(o_rd_index) && $stable(o_rd_byte) && $stable(o_status))

endmodule

bind i2c_register_master i2crm_chk u_i2crm_chk (.*);

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import i2crm_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;
    localparam int          ITEM_TARGET = 750;

    // One request as offered on the input channel
    typedef struct {
        t_op               op;
        logic              sda_in;
        logic [ADDR_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        logic [LEN_W-1:0]  xfer_len;
        logic [BUF_AW-1:0] wr_index;
        logic [BYTE_W-1:0] wr_byte;
    } t_request;

    // How the bus target behaves during one transaction
    typedef enum int {
        SC_WRITE_OK,
        SC_READ_OK,
        SC_START_FAIL_A,
        SC_START_FAIL_B,
        SC_ADDR_NACK,
        SC_DATA_NACK,
        SC_ZERO_LEN,
        SC_OVER_LEN,
        SC_REP_START_FAIL,
        SC_COUNT
    } t_scenario;

    // Line-level model of the master plus the queue of results it forecasts
    class i2c_line_tracker;
        logic [TICK_W-1:0] phase_ticks;
        t_phase            phase;
        int unsigned       tick_cnt;
        logic [BIT_W-1:0]  bit_cnt;
        int unsigned       byte_cnt;
        logic [BYTE_W-1:0] shifter;
        logic [BYTE_W-1:0] wbuf [BUF_DEPTH];
        logic [ADDR_W-1:0] dev_addr;
        logic [BYTE_W-1:0] reg_addr;
        int unsigned       xfer_len;
        bit                is_read;
        bit                scl;
        bit                sda;
        t_kind             kind;
        t_status           end_status;
        t_result           pulse;
        t_result           line_forecast [$];
        int                mismatches;

        function new();
            phase_ticks = DEF_PHASE_TICKS;
            phase       = PH_IDLE;
            tick_cnt    = 0;
            bit_cnt     = '0;
            byte_cnt    = 0;
            shifter     = '0;
            dev_addr    = '0;
            reg_addr    = '0;
            xfer_len    = 0;
            is_read     = 0;
            scl         = 1;
            sda         = 1;
            kind        = KIND_ADDR_W;
            end_status  = ST_OK;
            mismatches  = 0;
            foreach (wbuf[i]) wbuf[i] = '0;
        endfunction

        // Enter a phase and apply its line change
        function void go_to(t_phase ph);
            phase    = ph;
            tick_cnt = 0;
            case (ph)
                PH_ST_A: begin
                    sda = 1;
                    scl = 1;
                end
                PH_ST_B, PH_SP_SDA: sda = 0;
                PH_TX_LO, PH_AK_LO, PH_RX_LO, PH_MA_LO, PH_MA_END, PH_SP_LO: scl = 0;
                PH_TX_SET: sda = shifter[7];
                PH_TX_HI, PH_AK_HI, PH_RX_HI, PH_MA_HI, PH_SP_HI: scl = 1;
                PH_AK_REL, PH_SP_REL: sda = 1;
                PH_MA_SET: sda = (byte_cnt + 1 >= xfer_len);
                default: ;
            endcase
        endfunction

        function void close_out(t_status st);
            phase        = PH_IDLE;
            tick_cnt     = 0;
            pulse.done   = 1'b1;
            pulse.status = st;
        endfunction

        function void start_stop(t_status st);
            end_status = st;
            go_to(PH_SP_LO);
        endfunction

        function void load_byte(t_kind k);
            kind = k;
            case (k)
                KIND_ADDR_W: shifter = {dev_addr, 1'b0};
                KIND_REG:    shifter = reg_addr;
                KIND_DATA:   shifter = wbuf[byte_cnt % BUF_DEPTH];
                default:     shifter = {dev_addr, 1'b1};
            endcase
            bit_cnt = '0;
            go_to(PH_TX_LO);
        endfunction

        function void start_receive();
            sda     = 1;
            shifter = '0;
            bit_cnt = '0;
            go_to(PH_RX_LO);
        endfunction

        function void next_write_byte();
            if (byte_cnt >= xfer_len) start_stop(ST_OK);
            else load_byte(KIND_DATA);
        endfunction

        // A failed repeated START goes straight on to the read address, a failed first one aborts
        function void retry_or_abort();
            if (kind == KIND_ADDR_R) load_byte(KIND_ADDR_R);
            else close_out(ST_START_FAIL);
        endfunction

        // Act on the tick that ends the current phase
        function void phase_done(bit level);
            case (phase)
                PH_ST_A: if (!level) retry_or_abort(); else go_to(PH_ST_B);
                PH_ST_B: if (level) retry_or_abort(); else go_to(PH_ST_C);
                PH_ST_C: load_byte(kind);
                PH_TX_LO: go_to(PH_TX_SET);
                PH_TX_SET: go_to(PH_TX_HI);
                PH_TX_HI: begin
                    shifter = shifter << 1;
                    bit_cnt = bit_cnt + 1'b1;
                    go_to(bit_cnt >= BITS_PER_BYTE ? PH_AK_LO : PH_TX_LO);
                end
                PH_AK_LO: go_to(PH_AK_REL);
                PH_AK_REL: go_to(PH_AK_HI);
                PH_AK_HI: begin
                    scl = 0;
                    case (kind)
                        KIND_ADDR_W: begin
                            if (level) start_stop(ST_ADDR_NACK);
                            else load_byte(KIND_REG);
                        end
                        KIND_REG: begin
                            if (is_read) begin
                                kind = KIND_ADDR_R;
                                go_to(PH_ST_A);
                            end else begin
                                byte_cnt = 0;
                                next_write_byte();
                            end
                        end
                        KIND_DATA: begin
                            if (level) begin
                                start_stop(ST_DATA_NACK);
                            end else begin
                                byte_cnt = (byte_cnt + 1) % 32;
                                next_write_byte();
                            end
                        end
                        default: begin
                            byte_cnt = 0;
                            if (xfer_len == 0) start_stop(ST_OK);
                            else start_receive();
                        end
                    endcase
                end
                PH_RX_LO: go_to(PH_RX_HI);
                PH_RX_HI: begin
                    shifter = {shifter[BYTE_W-2:0], level};
                    bit_cnt = bit_cnt + 1'b1;
                    if (bit_cnt >= BITS_PER_BYTE) begin
                        pulse.rd_valid = 1'b1;
                        pulse.rd_index = BUF_AW'(byte_cnt % BUF_DEPTH);
                        pulse.rd_byte  = shifter;
                        go_to(PH_MA_LO);
                    end else begin
                        go_to(PH_RX_LO);
                    end
                end
                PH_MA_LO: go_to(PH_MA_SET);
                PH_MA_SET: go_to(PH_MA_HI);
                PH_MA_HI: go_to(PH_MA_END);
                PH_MA_END: begin
                    byte_cnt = (byte_cnt + 1) % 32;
                    if (byte_cnt >= xfer_len) start_stop(ST_OK);
                    else start_receive();
                end
                PH_SP_LO: go_to(PH_SP_SDA);
                PH_SP_SDA: go_to(PH_SP_HI);
                PH_SP_HI: go_to(PH_SP_REL);
                PH_SP_REL: close_out(end_status);
                default: phase = PH_IDLE;
            endcase
        endfunction

        // Note an accepted request; return 1 unless the master ignores it
        function bit apply_request(t_request r);
            int unsigned span;
            bit          acted;
            span  = (phase_ticks == 0) ? 1 : phase_ticks;
            pulse = '0;
            acted = 0;
            if (r.op == OP_TICK) begin
                if (phase != PH_IDLE) begin
                    acted    = 1;
                    tick_cnt = tick_cnt + 1;
                    if (tick_cnt >= span) phase_done(r.sda_in);
                end
            end else if (phase == PH_IDLE) begin
                acted = 1;
                if (r.op == OP_LOAD) begin
                    wbuf[r.wr_index] = r.wr_byte;
                end else begin
                    dev_addr   = r.dev_addr;
                    reg_addr   = r.reg_addr;
                    xfer_len   = (r.xfer_len > MAX_LEN) ? MAX_LEN : r.xfer_len;
                    is_read    = (r.op == OP_READ);
                    byte_cnt   = 0;
                    bit_cnt    = '0;
                    shifter    = '0;
                    end_status = ST_OK;
                    kind       = KIND_ADDR_W;
                    go_to(PH_ST_A);
                end
            end
            pulse.scl  = scl;
            pulse.sda  = sda;
            pulse.busy = (phase != PH_IDLE);
            line_forecast.push_back(pulse);
            return acted;
        endfunction

        function string describe(t_result x);
            return $sformatf({"scl=%b sda=%b rd_valid=%b rd_index=%0d rd_byte=%h ",
                              "busy=%b done=%b status=%0d"},
                             x.scl, x.sda, x.rd_valid, x.rd_index, x.rd_byte,
                             x.busy, x.done, x.status);
        endfunction

        // Check one accepted result against the oldest forecast
        function void compare_result(t_result got);
            t_result want;
            if (line_forecast.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing forecast: %s", describe(got));
                return;
            end
            want = line_forecast.pop_front();
            if (got.scl !== want.scl || got.sda !== want.sda ||
                got.rd_valid !== want.rd_valid || got.rd_index !== want.rd_index ||
                got.rd_byte !== want.rd_byte || got.busy !== want.busy ||
                got.done !== want.done || got.status !== want.status) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %s / got %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [1:0]          i_op;
    logic                i_sda_in;
    logic [ADDR_W-1:0]   i_dev_addr;
    logic [BYTE_W-1:0]   i_reg_addr;
    logic [LEN_W-1:0]    i_xfer_len;
    logic [BUF_AW-1:0]   i_wr_index;
    logic [BYTE_W-1:0]   i_wr_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_scl_out;
    logic                o_sda_out;
    logic                o_rd_valid;
    logic [BUF_AW-1:0]   o_rd_index;
    logic [BYTE_W-1:0]   o_rd_byte;
    logic                o_busy_res;
    logic                o_done_res;
    logic [1:0]          o_status;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [TICK_W-1:0]   i_cfg_data;

    i2c_line_tracker     tracker;

    // Target behavior for the transaction in flight
    bit                  fail_first_a;
    bit                  fail_first_b;
    bit                  fail_rep_a;
    bit                  fail_rep_b;
    bit                  nack_addr;
    int                  nack_at;
    logic [BYTE_W-1:0]   rx_bytes [BUF_DEPTH];

    bit                  sender_calm;
    bit                  receiver_calm;
    int                  effective_items;

    i2c_register_master dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_sda_in    (i_sda_in),
        .i_dev_addr  (i_dev_addr),
        .i_reg_addr  (i_reg_addr),
        .i_xfer_len  (i_xfer_len),
        .i_wr_index  (i_wr_index),
        .i_wr_byte   (i_wr_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_scl_out   (o_scl_out),
        .o_sda_out   (o_sda_out),
        .o_rd_valid  (o_rd_valid),
        .o_rd_index  (o_rd_index),
        .o_rd_byte   (o_rd_byte),
        .o_busy_res  (o_busy_res),
        .o_done_res  (o_done_res),
        .o_status    (o_status),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Request of the given opcode with every other field random
    function automatic t_request rand_req(t_op op);
        t_request r;
        r.op       = op;
        r.sda_in   = 1'($urandom_range(0, 1));
        r.dev_addr = ADDR_W'($urandom);
        r.reg_addr = BYTE_W'($urandom);
        r.xfer_len = LEN_W'($urandom);
        r.wr_index = BUF_AW'($urandom);
        r.wr_byte  = BYTE_W'($urandom);
        return r;
    endfunction

    // SDA as the bus target drives it on this tick, with a little noise
    function automatic bit target_sda();
        bit noise;
        noise = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 29) == 0) return noise;
        case (tracker.phase)
            PH_ST_A: return (tracker.kind == KIND_ADDR_R) ? !fail_rep_a : !fail_first_a;
            PH_ST_B: return (tracker.kind == KIND_ADDR_R) ? fail_rep_b : fail_first_b;
            PH_AK_HI: begin
                if (tracker.kind == KIND_ADDR_W) return nack_addr;
                if (tracker.kind == KIND_DATA) return int'(tracker.byte_cnt) == nack_at;
                return noise;
            end
            PH_RX_HI: return rx_bytes[tracker.byte_cnt % BUF_DEPTH][7 - tracker.bit_cnt];
            default: return noise;
        endcase
    endfunction

    // Offer one request after a random gap (none while the sender is calm) and hold it until accepted
    task automatic offer(input t_request r);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= r.op;
        i_sda_in   <= r.sda_in;
        i_dev_addr <= r.dev_addr;
        i_reg_addr <= r.reg_addr;
        i_xfer_len <= r.xfer_len;
        i_wr_index <= r.wr_index;
        i_wr_byte  <= r.wr_byte;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        if (tracker.apply_request(r)) effective_items++;
        if ($urandom_range(0, 59) == 0) sender_calm = !sender_calm;
    endtask

    // Drain all results, then write the phase length
    task automatic set_phase_ticks(input logic [TICK_W-1:0] value);
        i_in_valid <= 1'b0;
        while (tracker.line_forecast.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.phase_ticks = value;
    endtask

    // Run one register transaction to its end
    task automatic run_transaction(input t_scenario sc);
        t_request r;
        t_request extra;
        int       n;
        int       len;
        fail_first_a = (sc == SC_START_FAIL_A);
        fail_first_b = (sc == SC_START_FAIL_B);
        fail_rep_a   = (sc == SC_REP_START_FAIL) && ($urandom_range(0, 1) == 1);
        fail_rep_b   = (sc == SC_REP_START_FAIL) && !fail_rep_a;
        nack_addr    = (sc == SC_ADDR_NACK);
        foreach (rx_bytes[i]) rx_bytes[i] = BYTE_W'($urandom);

        // pick the command
        case (sc)
            SC_READ_OK, SC_REP_START_FAIL: r = rand_req(OP_READ);
            SC_DATA_NACK: r = rand_req(OP_WRITE);
            default: r = rand_req($urandom_range(0, 1) ? OP_READ : OP_WRITE);
        endcase
        case (sc)
            SC_ZERO_LEN: len = 0;
            SC_OVER_LEN: len = $urandom_range(MAX_LEN + 1, 31);
            default: len = ($urandom_range(0, 6) == 0) ? $urandom_range(4, 8)
                                                      : $urandom_range(1, 2);
        endcase
        r.xfer_len = LEN_W'(len);
        nack_at = (sc == SC_DATA_NACK) ? $urandom_range(0, len - 1) : -1;
        if ($urandom_range(0, 4) == 0) r.dev_addr = $urandom_range(0, 1) ? '1 : '0;
        if ($urandom_range(0, 4) == 0) r.reg_addr = $urandom_range(0, 1) ? '1 : '0;

        // a few buffer loads and idle ticks ahead of the command
        n = $urandom_range(0, 3);
        repeat (n) offer(rand_req($urandom_range(0, 1) ? OP_LOAD : OP_TICK));
        offer(r);

        // tick until the master goes idle, with stray commands now and then
        while (tracker.phase != PH_IDLE) begin
            if ($urandom_range(0, 24) == 0) begin
                offer(rand_req(t_op'($urandom_range(OP_LOAD, OP_READ))));
            end else begin
                extra = rand_req(OP_TICK);
                extra.sda_in = target_sda();
                offer(extra);
            end
        end
    endtask

    // Result side: random stall per result, one long hold-off
    initial begin : result_sink
        int      hold;
        int      taken;
        bit      held_long;
        t_result got;
        i_out_stall <= 1'b1;
        taken     = 0;
        held_long = 0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!held_long && taken >= 150) begin
                hold      = 250;
                held_long = 1;
            end else begin
                hold = receiver_calm ? 0 : $urandom_range(0, 10);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got.scl      = o_scl_out;
            got.sda      = o_sda_out;
            got.rd_valid = o_rd_valid;
            got.rd_index = o_rd_index;
            got.rd_byte  = o_rd_byte;
            got.busy     = o_busy_res;
            got.done     = o_done_res;
            got.status   = t_status'(o_status);
            tracker.compare_result(got);
            taken++;
            if ($urandom_range(0, 59) == 0) receiver_calm = !receiver_calm;
        end
    end

    // Stimulus and final verdict
    initial begin : stimulus
        t_request r;
        int       scen_n;
        tracker         = new();
        sender_calm     = 0;
        receiver_calm   = 0;
        effective_items = 0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_TICK;
        i_sda_in    <= 1'b1;
        i_dev_addr  <= '0;
        i_reg_addr  <= '0;
        i_xfer_len  <= '0;
        i_wr_index  <= '0;
        i_wr_byte   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill every buffer slot so no transaction sends an unwritten byte
        for (int i = 0; i < BUF_DEPTH; i++) begin
            r = rand_req(OP_LOAD);
            r.wr_index = BUF_AW'(i);
            if (i == 0) r.wr_byte = '0;
            else if (i == 1) r.wr_byte = '1;
            offer(r);
        end

        // default phase length, START rejected on its first check
        run_transaction(SC_START_FAIL_A);
        // longer phase length, START rejected on its second check
        set_phase_ticks(TICK_W'(37));
        run_transaction(SC_START_FAIL_B);
        // zero phase length behaves as one tick
        set_phase_ticks('0);

        // every scenario once, then random ones, at one-tick phases
        scen_n = 0;
        while (scen_n < SC_COUNT || effective_items < ITEM_TARGET) begin
            if (scen_n > 0 && $urandom_range(0, 3) == 0)
                set_phase_ticks(TICK_W'($urandom_range(0, 1)));
            if (scen_n < SC_COUNT) run_transaction(t_scenario'(scen_n));
            else run_transaction(t_scenario'($urandom_range(0, SC_COUNT - 1)));
            scen_n++;
        end

        // drain and let any stray result show up
        i_in_valid <= 1'b0;
        while (tracker.line_forecast.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.line_forecast.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Abort a hung run
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

endmodule
